@@ rtl/core/sha1_hash_core_macros.svh @@
// Assertion macros for the SHA-1 hash core.
// Depends on a clock named clk and an active-low reset named rst_n in the using module.
`ifndef SHA1_HASH_CORE_MACROS_SVH
`define SHA1_HASH_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SHA1C_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SHA1C_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/sha1c_pkg.sv @@
// Shared types, constants and round functions for the SHA-1 hash core.
// No dependencies; imported by every module of the core.
`default_nettype none

package sha1c_pkg;

    localparam int WORD_W      = 32;
    localparam int BLK_AW      = 4;
    localparam int CHAIN_WORDS = 5;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [CHAIN_WORDS-1:0][WORD_W-1:0] chain_t;

    localparam logic [6:0] SCHED_START = 7'd16;
    localparam logic [6:0] LAST_ROUND  = 7'd79;
    localparam logic [5:0] LEN_POS     = 6'd56;
    localparam logic [5:0] BLOCK_END   = 6'd63;
    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
    localparam logic [2:0] LAST_WORD_IDX = 3'd4;
    localparam logic [2:0] LAST_LEN_IDX  = 3'd7;

    localparam word_t K_R0 = 32'h5A827999;
    localparam word_t K_R1 = 32'h6ED9EBA1;
    localparam word_t K_R2 = 32'h8F1BBCDC;
    localparam word_t K_R3 = 32'hCA62C1D6;

    // Element 0 is the most significant digest word.
    localparam chain_t SHA1_IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                  32'hEFCDAB89, 32'h67452301};

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       has_byte;
        logic       final_item;
    } msg_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } dig_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RD,
        ST_RND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PAD_MARK,
        PAD_ZERO,
        PAD_LEN,
        PAD_DONE
    } pad_phase_t;

    typedef struct packed {
        logic load;
        logic step;
        logic fold;
        logic init;
    } round_ctrl_t;

    function automatic word_t round_f(input logic [6:0] rnd, input word_t b,
                                      input word_t c, input word_t d);
        word_t f;
        if (rnd < 7'd20) begin
            f = (b & c) | (~b & d);
        end else if (rnd < 7'd40) begin
            f = b ^ c ^ d;
        end else if (rnd < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

    function automatic word_t round_k(input logic [6:0] rnd);
        word_t k;
        if (rnd < 7'd20) begin
            k = K_R0;
        end else if (rnd < 7'd40) begin
            k = K_R1;
        end else if (rnd < 7'd60) begin
            k = K_R2;
        end else begin
            k = K_R3;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/sha1c_block_mem.sv @@
// Sixteen-word block and message schedule memory, one write and two read ports.
// Depends on sha1c_pkg; read data is registered and arrives in the cycle after the address.
`default_nettype none

module sha1c_block_mem
    import sha1c_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [BLK_AW-1:0] waddr,
    input  word_t             wdata,
    input  logic [BLK_AW-1:0] raddr0,
    input  logic [BLK_AW-1:0] raddr1,
    output word_t             rdata0,
    output word_t             rdata1
);

    word_t mem [2**BLK_AW];
    word_t rdata0_reg;
    word_t rdata1_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0_reg <= mem[raddr0];
        rdata1_reg <= mem[raddr1];
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

`default_nettype wire

@@ rtl/core/sha1c_round_unit.sv @@
// Working variables, one SHA-1 round per step, and the five-word chaining value.
// Depends on sha1c_pkg for the round functions and the initial value.
`default_nettype none

module sha1c_round_unit
    import sha1c_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  round_ctrl_t ctrl,
    input  logic [6:0]  rnd,
    input  word_t       w,
    output chain_t      chain
);

    word_t  a_reg, b_reg, c_reg, d_reg, e_reg;
    word_t  a_next, b_next, c_next, d_next, e_next;
    word_t  t_sum;
    chain_t chain_reg;
    chain_t chain_next;

    assign t_sum = {a_reg[26:0], a_reg[31:27]} + round_f(rnd, b_reg, c_reg, d_reg)
                 + e_reg + w + round_k(rnd);

    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        e_next = e_reg;
        if (ctrl.load)
        begin
            a_next = chain_reg[0];
            b_next = chain_reg[1];
            c_next = chain_reg[2];
            d_next = chain_reg[3];
            e_next = chain_reg[4];
        end
        else if (ctrl.step)
        begin
            a_next = t_sum;
            b_next = a_reg;
            c_next = {b_reg[1:0], b_reg[31:2]};
            d_next = c_reg;
            e_next = d_reg;
        end
    end

    always_comb
    begin
        chain_next = chain_reg;
        if (ctrl.init)
        begin
            chain_next = SHA1_IV;
        end
        else if (ctrl.fold)
        begin
            chain_next[0] = chain_reg[0] + a_reg;
            chain_next[1] = chain_reg[1] + b_reg;
            chain_next[2] = chain_reg[2] + c_reg;
            chain_next[3] = chain_reg[3] + d_reg;
            chain_next[4] = chain_reg[4] + e_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
        e_reg <= e_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= SHA1_IV;
        end
        else
        begin
            chain_reg <= chain_next;
        end
    end

    assign chain = chain_reg;

endmodule

`default_nettype wire

@@ rtl/core/sha1_hash_core.sv @@
// SHA-1 hash core: byte requests in, five digest words out.
// A byte that does not fill a block leaves the core free for the next request; the byte that fills
// it starts a compression (load, then a read and a round step for each of 80 rounds, then fold),
// as the three block memory reads of each schedule word share two read ports. A final request pads
// one byte per cycle, runs one or two compressions, then emits one word per cycle unless stalled.
// Reset (rst_n low, asynchronous) restores the initial chaining value and clears the length.
`default_nettype none
`include "sha1_hash_core_macros.svh"

module sha1_hash_core
    import sha1c_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic msg_valid,
    output logic msg_stall,
    input  msg_t msg,
    output logic dig_valid,
    input  logic dig_stall,
    output dig_t dig
);

    // Control state
    state_t     state_reg, state_next;
    logic [5:0] pos_reg, pos_next;
    logic [63:0] bits_reg, bits_next;
    logic [6:0] round_reg, round_next;
    logic       final_reg, final_next;
    pad_phase_t pad_reg, pad_next;
    logic [2:0] len_idx_reg, len_idx_next;
    logic [2:0] emit_idx_reg, emit_idx_next;
    logic       dig_valid_reg, dig_valid_next;

    // Payload registers
    word_t      word_acc_reg, word_acc_next;
    word_t      x_reg, x_next;
    word_t      wm1_reg, wm1_next;
    word_t      wm2_reg, wm2_next;
    word_t      wm3_reg, wm3_next;
    dig_t       dig_reg, dig_next;

    // Datapath and control signals
    logic              msg_accept;
    logic              ins_valid;
    logic [7:0]        ins_byte;
    logic [7:0]        pad_byte;
    logic [7:0]        len_byte;
    logic [63:0]       len_shift;
    word_t             word_ins;
    logic [5:0]        pos_inc;
    logic              block_full;
    logic              dig_load;
    logic              emit_last;
    word_t             q0, q1;
    word_t             xq;
    word_t             w;
    logic              mem_we;
    logic [BLK_AW-1:0] mem_waddr;
    word_t             mem_wdata;
    logic [BLK_AW-1:0] mem_raddr0;
    logic [BLK_AW-1:0] mem_raddr1;
    logic [BLK_AW-1:0] rd_base;
    round_ctrl_t       rctl;
    chain_t            chain;

    // Take a request only between messages or blocks, never while busy.
    assign msg_stall  = (state_reg != ST_IDLE);
    assign msg_accept = msg_valid && !msg_stall;

    // Length bytes go out most significant first.
    assign len_shift = bits_reg >> {~len_idx_reg, 3'b000};
    assign len_byte  = len_shift[7:0];

    always_comb
    begin
        case (pad_reg)
            PAD_MARK: pad_byte = PAD_MARK_BYTE;
            PAD_LEN:  pad_byte = len_byte;
            default:  pad_byte = 8'h00;
        endcase
    end

    // Merge the incoming byte into the big-endian word being assembled.
    always_comb
    begin
        case (pos_reg[1:0])
            2'd0:    word_ins = {ins_byte, 24'h000000};
            2'd1:    word_ins = {word_acc_reg[31:24], ins_byte, 16'h0000};
            2'd2:    word_ins = {word_acc_reg[31:16], ins_byte, 8'h00};
            default: word_ins = {word_acc_reg[31:8], ins_byte};
        endcase
    end

    assign pos_inc    = pos_reg + 6'd1;
    assign block_full = ins_valid && (pos_reg == BLOCK_END);

    // Schedule word: the first sixteen come straight from the block, later ones
    // combine W[r-3] (held in wm3), W[r-8], W[r-14] and W[r-16] from memory.
    assign xq = x_reg ^ q0;
    assign w  = (round_reg < SCHED_START) ? q0 : {xq[30:0], xq[31]};

    assign dig_load  = (state_reg == ST_EMIT) && (!dig_valid_reg || !dig_stall);
    assign emit_last = dig_load && (emit_idx_reg == LAST_WORD_IDX);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg_accept)
                begin
                    if (block_full)
                    begin
                        state_next = ST_LOAD;
                    end
                    else if (msg.final_item)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_LOAD:
            begin
                state_next = ST_RD;
            end
            ST_RD:
            begin
                state_next = ST_RND;
            end
            ST_RND:
            begin
                state_next = (round_reg == LAST_ROUND) ? ST_FOLD : ST_RD;
            end
            ST_FOLD:
            begin
                if (!final_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (pad_reg == PAD_DONE)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (block_full)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_EMIT:
            begin
                if (emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs per state
    always_comb
    begin
        ins_valid = 1'b0;
        ins_byte  = 8'h00;
        rctl      = '0;
        mem_we    = 1'b0;
        mem_waddr = round_reg[3:0];
        mem_wdata = w;
        rd_base   = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ins_valid = msg_accept && msg.has_byte;
                ins_byte  = msg.msg_byte;
            end
            ST_PAD:
            begin
                ins_valid = 1'b1;
                ins_byte  = pad_byte;
            end
            ST_LOAD:
            begin
                rctl.load = 1'b1;
            end
            ST_RD:
            begin
                rctl = '0;
            end
            ST_RND:
            begin
                rctl.step = 1'b1;
                mem_we    = (round_reg >= SCHED_START);
                rd_base   = round_reg[3:0] + 4'd1;
            end
            ST_FOLD:
            begin
                rctl.fold = 1'b1;
            end
            ST_EMIT:
            begin
                rctl.init = emit_last;
            end
            default:
            begin
                rctl = '0;
            end
        endcase

        // Write back each completed word of the block.
        if (ins_valid && (pos_reg[1:0] == 2'd3))
        begin
            mem_we    = 1'b1;
            mem_waddr = pos_reg[5:2];
            mem_wdata = word_ins;
        end

        // Issue W[r-8] and W[r-14] ahead, then W[r-16] in the read cycle.
        mem_raddr0 = (state_reg == ST_RD) ? round_reg[3:0] : rd_base + 4'd8;
        mem_raddr1 = rd_base + 4'd2;
    end

    // Register next values
    always_comb
    begin
        pos_next       = pos_reg;
        bits_next      = bits_reg;
        round_next     = round_reg;
        final_next     = final_reg;
        pad_next       = pad_reg;
        len_idx_next   = len_idx_reg;
        emit_idx_next  = emit_idx_reg;
        word_acc_next  = word_acc_reg;
        x_next         = x_reg;
        wm1_next       = wm1_reg;
        wm2_next       = wm2_reg;
        wm3_next       = wm3_reg;
        dig_next       = dig_reg;
        dig_valid_next = dig_stall ? dig_valid_reg : 1'b0;

        if (ins_valid)
        begin
            pos_next      = pos_inc;
            word_acc_next = word_ins;
        end

        if (msg_accept && msg.has_byte)
        begin
            bits_next = bits_reg + 64'd8;
        end

        if (msg_accept && msg.final_item)
        begin
            final_next   = 1'b1;
            pad_next     = PAD_MARK;
            len_idx_next = 3'd0;
        end

        if (state_reg == ST_PAD)
        begin
            case (pad_reg) inside
                PAD_MARK, PAD_ZERO:
                begin
                    pad_next = (pos_inc == LEN_POS) ? PAD_LEN : PAD_ZERO;
                end
                PAD_LEN:
                begin
                    len_idx_next = len_idx_reg + 3'd1;
                    if (len_idx_reg == LAST_LEN_IDX)
                    begin
                        pad_next = PAD_DONE;
                    end
                end
                default:
                begin
                    pad_next = pad_reg;
                end
            endcase
        end

        if (state_reg == ST_LOAD)
        begin
            round_next = '0;
        end

        if (state_reg == ST_RD)
        begin
            x_next = q0 ^ q1 ^ wm3_reg;
        end

        if (state_reg == ST_RND)
        begin
            round_next = (round_reg == LAST_ROUND) ? 7'd0 : round_reg + 7'd1;
            wm1_next   = w;
            wm2_next   = wm1_reg;
            wm3_next   = wm2_reg;
        end

        if (dig_load)
        begin
            dig_valid_next      = 1'b1;
            dig_next.digest_word = chain[emit_idx_reg];
            dig_next.word_index  = emit_idx_reg;
            dig_next.last_word   = (emit_idx_reg == LAST_WORD_IDX);
            emit_idx_next        = (emit_idx_reg == LAST_WORD_IDX) ? 3'd0
                                                                   : emit_idx_reg + 3'd1;
        end

        // Drop the message length and end mark once the last digest word is loaded for output.
        if (emit_last)
        begin
            bits_next  = '0;
            final_next = 1'b0;
            pos_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            bits_reg      <= '0;
            round_reg     <= '0;
            final_reg     <= 1'b0;
            pad_reg       <= PAD_DONE;
            len_idx_reg   <= '0;
            emit_idx_reg  <= '0;
            dig_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            bits_reg      <= bits_next;
            round_reg     <= round_next;
            final_reg     <= final_next;
            pad_reg       <= pad_next;
            len_idx_reg   <= len_idx_next;
            emit_idx_reg  <= emit_idx_next;
            dig_valid_reg <= dig_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_acc_reg <= word_acc_next;
        x_reg        <= x_next;
        wm1_reg      <= wm1_next;
        wm2_reg      <= wm2_next;
        wm3_reg      <= wm3_next;
        dig_reg      <= dig_next;
    end

    sha1c_block_mem u_block_mem (
        .clk    (clk),
        .we     (mem_we),
        .waddr  (mem_waddr),
        .wdata  (mem_wdata),
        .raddr0 (mem_raddr0),
        .raddr1 (mem_raddr1),
        .rdata0 (q0),
        .rdata1 (q1)
    );

    sha1c_round_unit u_round_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (rctl),
        .rnd   (round_reg),
        .w     (w),
        .chain (chain)
    );

    assign dig_valid = dig_valid_reg;
    assign dig       = dig_reg;

    `SHA1C_ASSERT_IMP(a_round_bound, (state_reg == ST_RD) || (state_reg == ST_RND), round_reg <= LAST_ROUND, "round counter out of range")
    `SHA1C_ASSERT_IMP(a_load_empty_block, state_reg == ST_LOAD, pos_reg == 6'd0, "compression started on a partial block")
    `SHA1C_ASSERT_IMP(a_len_position, (state_reg == ST_PAD) && (pad_reg == PAD_LEN), (pos_reg[5:3] == 3'd7) && (pos_reg[2:0] == len_idx_reg), "length byte misplaced in block")
    `SHA1C_ASSERT_IMP(a_last_word_index, dig_valid_reg && dig_reg.last_word, dig_reg.word_index == LAST_WORD_IDX, "last word flag on wrong digest word")
    `SHA1C_ASSERT_NEXT(a_emit_restart, emit_last, (state_reg == ST_IDLE) && (bits_reg == 64'd0) && !final_reg, "message state not cleared after digest")

endmodule

`default_nettype wire

@@ verif/sha1_hash_core_test.sv @@
// Self-checking testbench for sha1_hash_core: byte requests in, digest words out.
// Depends on sha1c_pkg (request and digest types, chaining constants) and the core RTL.
`default_nettype none

module sha1_hash_core_test;
    import sha1c_pkg::*;

    // Track the running SHA-1 state of the message in flight and hold the
    // digest words that the core still owes.
    class sha1_scoreboard;
        word_t       chain [5];
        logic [7:0]  blk [64];
        int          fill;
        logic [63:0] bit_len;
        dig_t        digest_q [$];
        int          errors;
        int          words_checked;

        function new();
            restart();
            errors = 0;
            words_checked = 0;
        endfunction

        // Go back to the initial chaining value with an empty message.
        function void restart();
            for (int i = 0; i < 5; i++)
            begin
                chain[i] = SHA1_IV[i];
            end
            fill = 0;
            bit_len = '0;
        endfunction

        static function word_t rotl(word_t v, int n);
            return (v << n) | (v >> (32 - n));
        endfunction

        // Run the 80 rounds over the buffered block and fold into the chain.
        function void compress();
            word_t w [16];
            word_t a, b, c, d, e, f, k, t, wi;
            for (int i = 0; i < 16; i++)
            begin
                w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            end
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            e = chain[4];
            for (int r = 0; r < 80; r++)
            begin
                if (r < 16)
                begin
                    wi = w[r];
                end
                else
                begin
                    wi = rotl(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[r % 16], 1);
                    w[r % 16] = wi;
                end
                if (r < 20)
                begin
                    f = (b & c) | (~b & d);
                    k = K_R0;
                end
                else if (r < 40)
                begin
                    f = b ^ c ^ d;
                    k = K_R1;
                end
                else if (r < 60)
                begin
                    f = (b & c) | (b & d) | (c & d);
                    k = K_R2;
                end
                else
                begin
                    f = b ^ c ^ d;
                    k = K_R3;
                end
                t = rotl(a, 5) + f + e + wi + k;
                e = d;
                d = c;
                c = rotl(b, 30);
                b = a;
                a = t;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
            chain[4] += e;
        endfunction

        function void absorb(logic [7:0] data);
            blk[fill] = data;
            fill++;
            if (fill == 64)
            begin
                compress();
                fill = 0;
            end
        endfunction

        // Note one accepted request; on an end mark, pad and queue the digest.
        function void note_request(msg_t m);
            logic [63:0] len;
            dig_t        word;
            if (m.has_byte)
            begin
                absorb(m.msg_byte);
                bit_len += 64'd8;
            end
            if (!m.final_item)
            begin
                return;
            end
            len = bit_len;
            absorb(PAD_MARK_BYTE);
            while (fill != int'(LEN_POS))
            begin
                absorb(8'h00);
            end
            for (int i = 0; i < 8; i++)
            begin
                absorb(len[63 - 8*i -: 8]);
            end
            for (int i = 0; i < 5; i++)
            begin
                word.digest_word = chain[i];
                word.word_index  = 3'(i);
                word.last_word   = (3'(i) == LAST_WORD_IDX);
                digest_q.push_back(word);
            end
            restart();
        endfunction

        // Compare one accepted digest word with the oldest expected word.
        function void check_digest(dig_t got);
            dig_t want;
            words_checked++;
            if (digest_q.size() == 0)
            begin
                $display("%0t: unexpected digest word %h (index %0d, last %0b)",
                         $time, got.digest_word, got.word_index, got.last_word);
                errors++;
                return;
            end
            want = digest_q.pop_front();
            if (got.digest_word !== want.digest_word)
            begin
                $display("%0t: digest_word mismatch: expected %h, actual %h",
                         $time, want.digest_word, got.digest_word);
                errors++;
            end
            if (got.word_index !== want.word_index)
            begin
                $display("%0t: word_index mismatch: expected %0d, actual %0d",
                         $time, want.word_index, got.word_index);
                errors++;
            end
            if (got.last_word !== want.last_word)
            begin
                $display("%0t: last_word mismatch: expected %0b, actual %0b",
                         $time, want.last_word, got.last_word);
                errors++;
            end
        endfunction
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic msg_valid = 1'b0;
    logic msg_stall;
    msg_t msg       = '0;
    logic dig_valid;
    logic dig_stall = 1'b0;
    dig_t dig;

    sha1_scoreboard sb = new();

    // Requests that carry a byte or an end mark; ignored requests stay out.
    int items_sent = 0;
    bit long_hold_done = 1'b0;

    sha1_hash_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .msg       (msg),
        .dig_valid (dig_valid),
        .dig_stall (dig_stall),
        .dig       (dig)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic msg_t make_request(logic [7:0] data, logic has, logic fin);
        msg_t m;
        m.msg_byte   = data;
        m.has_byte   = has;
        m.final_item = fin;
        return m;
    endfunction

    // Offer one request starting at a falling edge. Idle first at random
    // (except in the calm window), then hold the payload until accepted and
    // return at the next falling edge with valid still high.
    task automatic send_request(input msg_t m);
        while (!(items_sent >= 120 && items_sent < 170) && $urandom_range(0, 99) < 7)
        begin
            msg_valid <= 1'b0;
            @(negedge clk);
        end
        msg       <= m;
        msg_valid <= 1'b1;
        @(posedge clk);
        while (msg_stall)
        begin
            @(posedge clk);
        end
        sb.note_request(m);
        if (m.has_byte || m.final_item)
        begin
            items_sent++;
        end
        @(negedge clk);
    endtask

    // Check every digest word the core hands over.
    always @(posedge clk)
    begin
        if (rst_n && dig_valid && !dig_stall)
        begin
            sb.check_digest(dig);
        end
    end

    // Drive the receiver stall at falling edges: random back-pressure, a calm
    // stretch, and one long hold that backs the core up into its input.
    initial
    begin
        @(negedge clk);
        forever
        begin
            if (!long_hold_done && sb.words_checked >= 27)
            begin
                long_hold_done = 1'b1;
                dig_stall <= 1'b1;
                repeat (700) @(negedge clk);
            end
            else
            begin
                dig_stall <= !(sb.words_checked >= 45 && sb.words_checked < 75) &&
                             ($urandom_range(0, 99) < 7);
                @(negedge clk);
            end
        end
    end

    // Stimulus: directed messages, then random messages of mixed length.
    initial
    begin
        int len;
        int msgs;
        bit byte_on_end;
        int sel;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty message: a lone end mark with no byte.
        send_request(make_request(8'h00, 1'b0, 1'b1));
        // "abc" with an ignored request in the middle; last byte rides the end mark.
        send_request(make_request(8'h61, 1'b1, 1'b0));
        send_request(make_request(8'hA5, 1'b0, 1'b0));
        send_request(make_request(8'h62, 1'b1, 1'b0));
        send_request(make_request(8'h63, 1'b1, 1'b1));
        // Single byte at the top of the range, ending on it.
        send_request(make_request(8'hFF, 1'b1, 1'b1));
        // Extreme bytes, then an empty end mark whose ignored byte is all ones.
        send_request(make_request(8'h00, 1'b1, 1'b0));
        send_request(make_request(8'hFF, 1'b1, 1'b0));
        send_request(make_request(8'h80, 1'b1, 1'b0));
        send_request(make_request(8'hFF, 1'b0, 1'b1));

        // Random messages: mostly short, some across the 55/56/64 byte pad
        // boundaries, a few spanning more than one block.
        msgs = 0;
        while (items_sent < 190 || msgs < 7)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 70)
            begin
                len = $urandom_range(0, 10);
            end
            else if (sel < 92)
            begin
                len = $urandom_range(52, 68);
            end
            else
            begin
                len = $urandom_range(100, 130);
            end
            byte_on_end = (len > 0) && $urandom_range(0, 1);

            // Let the core drain completely once before the next message.
            if (msgs == 5)
            begin
                msg_valid <= 1'b0;
                while (sb.digest_q.size() != 0)
                begin
                    @(negedge clk);
                end
            end

            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 99) < 5)
                begin
                    send_request(make_request(8'($urandom_range(0, 255)), 1'b0, 1'b0));
                end
                send_request(make_request(8'($urandom_range(0, 255)), 1'b1,
                                          byte_on_end && (i == len - 1)));
            end
            if (!byte_on_end)
            begin
                send_request(make_request(8'($urandom_range(0, 255)), 1'b0, 1'b1));
            end
            msgs++;
        end
        msg_valid <= 1'b0;

        // Drain, then allow time for any stray word to show up.
        while (sb.digest_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (400) @(posedge clk);

        if (sb.errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    // Stop a hung run.
    initial
    begin
        #800000;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
